/* src/bse_pkg.sv */
// ----------------------------------------------------------------------------
// bse_pkg
// Shared types, codes and default sizes for the bounded set engine.
// ----------------------------------------------------------------------------
package bse_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int ELEM_WIDTH_DEF = 32;

  // Fixed widths of the beat fields
  localparam int REQ_W    = 2;
  localparam int IN_ELEM_W = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE     = 2'd0,
    STAT_NO_CHG   = 2'd1,
    STAT_REJ_FULL = 2'd2
  } status_t;

  // Update commands broadcast to every cell
  typedef struct packed {
    logic do_ins;
    logic do_del;
  } cell_ctl_t;

endpackage

/* src/bse_if.sv */
// ----------------------------------------------------------------------------
// bse_in_if / bse_out_if
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface bse_in_if;
  logic                          valid;
  logic                          ready;
  logic [bse_pkg::REQ_W-1:0]     req_type;
  logic signed [bse_pkg::IN_ELEM_W-1:0] element;

  modport source (output valid, req_type, element, input ready);
  modport sink   (input valid, req_type, element, output ready);
endinterface

interface bse_out_if;
  logic                          valid;
  logic                          ready;
  logic                          was_member;
  logic [bse_pkg::STATUS_W-1:0]  status;
  logic [bse_pkg::COUNT_W-1:0]   count;
  logic                          is_empty;
  logic                          is_full;

  modport source (output valid, was_member, status, count, is_empty, is_full,
                  input ready);
  modport sink   (input valid, was_member, status, count, is_empty, is_full,
                  output ready);
endinterface

/* src/bse_cell.sv */
// ----------------------------------------------------------------------------
// bse_cell
// One slot of the packed store: holds an element, flags a match against
// the captured key and takes its right neighbor's element on a delete.
// ----------------------------------------------------------------------------
module bse_cell #(
  parameter int CAPACITY   = bse_pkg::CAPACITY_DEF,
  parameter int ELEM_WIDTH = bse_pkg::ELEM_WIDTH_DEF,
  parameter int IDX        = 0,
  localparam int CNT_W     = $clog2(CAPACITY + 1)
) (
  input  logic                  clk,
  input  logic                  capture,
  input  logic [ELEM_WIDTH-1:0] key,
  input  logic [CNT_W-1:0]      count,
  input  bse_pkg::cell_ctl_t    ctl,
  input  logic [ELEM_WIDTH-1:0] nbr_data,
  input  logic                  hit_in,
  output logic [ELEM_WIDTH-1:0] data,
  output logic                  hit_out,
  output logic                  match
);

  logic [ELEM_WIDTH-1:0] data_r;
  logic                  match_r;
  logic                  occupied;

  assign occupied = CNT_W'(IDX) < count;

  // hit_out: a match sits in this cell or somewhere to the left
  assign hit_out = hit_in | match_r;
  assign data    = data_r;
  assign match   = match_r;

  always_ff @(posedge clk) begin
    if (capture) begin
      match_r <= occupied && (data_r == key);
    end
    if (ctl.do_ins && (count == CNT_W'(IDX))) begin
      data_r <= key;
    end else if (ctl.do_del && hit_out) begin
      data_r <= nbr_data;
    end
  end

endmodule

/* src/bounded_set_engine.sv */
// ----------------------------------------------------------------------------
// bounded_set_engine
// Set of up to CAPACITY distinct elements kept packed in a row of cells.
// Flow: a request beat is taken only in idle, when the cells register their
//   match; the update state then applies it through the cell row's hit chain
//   and registers the result beat; it stalls only while a result waits.
// Reset: rst_n clears the count, state and output valid; cell contents
//   are left as they are and only read below the count.
// ----------------------------------------------------------------------------
module bounded_set_engine #(
  parameter int CAPACITY   = bse_pkg::CAPACITY_DEF,
  parameter int ELEM_WIDTH = bse_pkg::ELEM_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  bse_in_if.sink       in_ch,
  bse_out_if.source    out_ch
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_UPD  = 2'b10
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [ELEM_WIDTH-1:0]   key_r;
  bse_pkg::req_t           req_r;

  logic                    out_valid_r, out_valid_nxt;
  logic                    was_member_r;
  bse_pkg::status_t        status_r, status_nxt;
  logic [CNT_W-1:0]        res_count_r;

  logic                    accept;
  logic                    advance;
  logic                    present;
  bse_pkg::cell_ctl_t      ctl;

  logic [ELEM_WIDTH-1:0]   in_key;
  logic [ELEM_WIDTH-1:0]   cell_data [CAPACITY];
  logic [CAPACITY:0]       hit;
  logic [CAPACITY-1:0]     match_vec;

  assign in_key  = ELEM_WIDTH'($unsigned(in_ch.element));
  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept  = in_ch.valid && in_ch.ready;
  assign advance = (state_r == ST_UPD) && (!out_valid_r || out_ch.ready);
  assign present = hit[CAPACITY];

  assign hit[0] = 1'b0;

  // Cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ELEM_WIDTH-1:0] nbr;
    if (i == CAPACITY - 1) begin : g_last
      assign nbr = cell_data[i];
    end else begin : g_mid
      assign nbr = cell_data[i+1];
    end
    bse_cell #(
      .CAPACITY   (CAPACITY),
      .ELEM_WIDTH (ELEM_WIDTH),
      .IDX        (i)
    ) u_cell (
      .clk      (clk),
      .capture  (accept),
      .key      (accept ? in_key : key_r),
      .count    (count_r),
      .ctl      (ctl),
      .nbr_data (nbr),
      .hit_in   (hit[i]),
      .data     (cell_data[i]),
      .hit_out  (hit[i+1]),
      .match    (match_vec[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    ctl           = '0;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (advance) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          status_nxt    = bse_pkg::STAT_DONE;
          case (req_r)
            bse_pkg::REQ_INSERT: begin
              if (present) begin
                status_nxt = bse_pkg::STAT_NO_CHG;
              end else if (count_r == CNT_W'(CAPACITY)) begin
                status_nxt = bse_pkg::STAT_REJ_FULL;
              end else begin
                ctl.do_ins = 1'b1;
                count_nxt  = count_r + 1'b1;
              end
            end
            bse_pkg::REQ_DELETE: begin
              if (present) begin
                ctl.do_del = 1'b1;
                count_nxt  = count_r - 1'b1;
              end else begin
                status_nxt = bse_pkg::STAT_NO_CHG;
              end
            end
            bse_pkg::REQ_QUERY: begin
            end
            bse_pkg::REQ_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r <= in_key;
      req_r <= bse_pkg::req_t'(in_ch.req_type);
    end
    if (advance) begin
      was_member_r <= present;
      status_r     <= status_nxt;
      res_count_r  <= count_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.was_member = was_member_r;
  assign out_ch.status     = status_r;
  assign out_ch.count      = bse_pkg::COUNT_W'(res_count_r);
  assign out_ch.is_empty   = (res_count_r == '0);
  assign out_ch.is_full    = (res_count_r == CNT_W'(CAPACITY));

  // Assertions
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("count exceeds capacity");

  a_accept_to_upd: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_UPD))
    else $error("request beat did not enter update");

  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |-> $onehot0(match_vec))
    else $error("element matched in more than one cell");

  a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == bse_pkg::STAT_REJ_FULL) |->
      (res_count_r == CNT_W'(CAPACITY)))
    else $error("full rejection with room left");

endmodule
